// ===== design/prfl_pkg.sv =====
// Package for the page replacement unit: field widths, register indexes
// and policy codes shared by the design. Depends on nothing.
package prfl_pkg;

	localparam int COUNT_BITS     = 4;
	localparam int SLOT_BITS      = 3;
	localparam int RANK_BITS      = 3;
	localparam int FAULT_BITS     = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 4;

	localparam logic [RANK_BITS-1:0] RANK_MAX = {RANK_BITS{1'b1}};
	localparam logic [FAULT_BITS-1:0] FAULT_MAX = {FAULT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] FRAME_COUNT_RESET = COUNT_BITS'(4);

	typedef enum logic {
		POLICY_FIFO = 1'b0,
		POLICY_LRU  = 1'b1
	} policy_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_POLICY_MODE = 2'd0,
		REG_FRAME_COUNT = 2'd1
	} reg_index_t;

endpackage

// ===== design/page_replacement_fifo_lru_unit.sv =====
// Page replacement unit top level, FIFO or LRU victim choice over up to MAX_FRAMES frames.
// An accepted word passes the input register, then the output register; throughput one
// word per cycle unless out_ready stalls, set by the tag compare and frame/rank update.
// Reset clears frame valid bits, recency ranks, FIFO pointer and fault count at once;
// policy resets to FIFO and frame count to 4. Stored page numbers are not reset.
// Depends on prfl_pkg.
module page_replacement_fifo_lru_unit #(
	parameter int MAX_FRAMES = 8,
	parameter int PAGE_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [prfl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [prfl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [PAGE_BITS-1:0]               page_number,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               hit,
	output logic [prfl_pkg::SLOT_BITS-1:0]      slot,
	output logic                               evicted_valid,
	output logic [PAGE_BITS-1:0]               evicted_page,
	output logic [prfl_pkg::FAULT_BITS-1:0]     fault_total
);
	import prfl_pkg::*;

	localparam int IDX_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int N_BITS   = COUNT_BITS + 1;
	localparam logic [N_BITS-1:0] N_MAX = N_BITS'(MAX_FRAMES);

	policy_t                policy_q;
	logic [COUNT_BITS-1:0]  frame_count_q;

	logic                   s1_valid;
	logic [PAGE_BITS-1:0]   page_s1;

	logic [PAGE_BITS-1:0]   frame_page_q [MAX_FRAMES];
	logic [MAX_FRAMES-1:0]  frame_valid_q;
	logic [RANK_BITS-1:0]   rank_q [MAX_FRAMES];
	logic [IDX_BITS-1:0]    fifo_q;
	logic [FAULT_BITS-1:0]  fault_q;

	logic                   out_valid_q;
	logic                   hit_q;
	logic [SLOT_BITS-1:0]   slot_q;
	logic                   evicted_valid_q;
	logic [PAGE_BITS-1:0]   evicted_page_q;

	logic                   advance;
	logic                   commit;
	logic [N_BITS-1:0]      n_c;
	logic [MAX_FRAMES-1:0]  active_c;
	logic [MAX_FRAMES-1:0]  hit_vec_c;
	logic [MAX_FRAMES-1:0]  empty_vec_c;
	logic                   hit_c;
	logic                   found_c;
	logic [IDX_BITS-1:0]    hit_idx_c;
	logic [IDX_BITS-1:0]    empty_idx_c;
	logic [IDX_BITS-1:0]    fifo_idx_c;
	logic [IDX_BITS-1:0]    fifo_next_c;
	logic [N_BITS-1:0]      fifo_inc_c;
	logic [(1<<RANK_BITS)-1:0] rank_has_c;
	logic [RANK_BITS-1:0]   rank_max_c;
	logic [MAX_FRAMES-1:0]  lru_vec_c;
	logic [IDX_BITS-1:0]    lru_idx_c;
	logic [IDX_BITS-1:0]    slot_c;
	logic                   evict_c;
	logic [RANK_BITS:0]     old_rank_c;
	logic [RANK_BITS-1:0]   rank_next_c [MAX_FRAMES];

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !s1_valid || advance;
	assign commit    = s1_valid && advance;

	always_comb begin
		if (frame_count_q == '0) begin
			n_c = N_BITS'(1);
		end else if (N_BITS'(frame_count_q) > N_MAX) begin
			n_c = N_MAX;
		end else begin
			n_c = N_BITS'(frame_count_q);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			active_c[i]    = N_BITS'(i) < n_c;
			hit_vec_c[i]   = active_c[i] && frame_valid_q[i] && (frame_page_q[i] == page_s1);
			empty_vec_c[i] = active_c[i] && !frame_valid_q[i];
		end
		hit_c   = |hit_vec_c;
		found_c = |empty_vec_c;
	end

	// lowest set index of each vector
	always_comb begin
		hit_idx_c   = '0;
		empty_idx_c = '0;
		lru_idx_c   = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (hit_vec_c[i]) begin
				hit_idx_c = IDX_BITS'(i);
			end
			if (empty_vec_c[i]) begin
				empty_idx_c = IDX_BITS'(i);
			end
			if (lru_vec_c[i]) begin
				lru_idx_c = IDX_BITS'(i);
			end
		end
	end

	always_comb begin
		fifo_idx_c  = (N_BITS'(fifo_q) < n_c) ? fifo_q : '0;
		fifo_inc_c  = N_BITS'(fifo_idx_c) + N_BITS'(1);
		fifo_next_c = (fifo_inc_c < n_c) ? IDX_BITS'(fifo_inc_c) : '0;
	end

	always_comb begin
		rank_has_c = '0;
		for (int r = 0; r < (1 << RANK_BITS); r++) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				if (active_c[i] && (rank_q[i] == RANK_BITS'(r))) begin
					rank_has_c[r] = 1'b1;
				end
			end
		end
		rank_max_c = '0;
		for (int r = 0; r < (1 << RANK_BITS); r++) begin
			if (rank_has_c[r]) begin
				rank_max_c = RANK_BITS'(r);
			end
		end
		for (int i = 0; i < MAX_FRAMES; i++) begin
			lru_vec_c[i] = active_c[i] && (rank_q[i] == rank_max_c);
		end
	end

	always_comb begin
		evict_c = !hit_c && !found_c;
		if (hit_c) begin
			slot_c = hit_idx_c;
		end else if (found_c) begin
			slot_c = empty_idx_c;
		end else if (policy_q == POLICY_FIFO) begin
			slot_c = fifo_idx_c;
		end else begin
			slot_c = lru_idx_c;
		end
		old_rank_c = found_c && !hit_c ? (RANK_BITS + 1)'(RANK_MAX) + 1'b1
		                               : {1'b0, rank_q[slot_c]};
		for (int i = 0; i < MAX_FRAMES; i++) begin
			if (IDX_BITS'(i) == slot_c) begin
				rank_next_c[i] = '0;
			end else if (active_c[i] && frame_valid_q[i] && ({1'b0, rank_q[i]} < old_rank_c)
			             && (rank_q[i] != RANK_MAX)) begin
				rank_next_c[i] = rank_q[i] + 1'b1;
			end else begin
				rank_next_c[i] = rank_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= POLICY_FIFO;
			frame_count_q <= FRAME_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POLICY_MODE: policy_q <= policy_t'(cfg_data[0]);
				REG_FRAME_COUNT: frame_count_q <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			page_s1 <= page_number;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && !hit_c) begin
			frame_page_q[slot_c] <= page_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= '0;
			fifo_q        <= '0;
			fault_q       <= '0;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (commit) begin
			frame_valid_q[slot_c] <= 1'b1;
			rank_q <= rank_next_c;
			if (evict_c && (policy_q == POLICY_FIFO)) begin
				fifo_q <= fifo_next_c;
			end
			if (!hit_c && (fault_q != FAULT_MAX)) begin
				fault_q <= fault_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q           <= hit_c;
			slot_q          <= SLOT_BITS'(slot_c);
			evicted_valid_q <= evict_c;
			evicted_page_q  <= evict_c ? frame_page_q[slot_c] : '0;
			fault_total     <= (!hit_c && (fault_q != FAULT_MAX)) ? fault_q + 1'b1 : fault_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;

	a_fault_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q >= $past(fault_q))
		else $error("fault count decreased");

	a_fault_fills_frame: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !hit_c |=> frame_valid_q[$past(slot_c)])
		else $error("faulted frame not marked valid");

	a_touch_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rank_q[$past(slot_c)] == '0)
		else $error("referenced frame not most recent");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> s1_valid && out_valid_q && !out_ready)
		else $error("input stalled without a held result");

endmodule
